// ----- rtl/l96rk4_pkg.sv -----
// ----------------------------------------------------------------------------
// l96rk4_pkg: shared types and constants for the Lorenz-96 RK4 stepper
// Transaction structs, sequencer states, register codes, and the 32-bit
// saturation helper.
// ----------------------------------------------------------------------------
package l96rk4_pkg;

  localparam int MAX_ELEMENTS_DEF  = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int VAL_W     = 32;
  localparam int STEP_W    = 17;
  localparam int FORCE_W   = 25;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;

  // shared unit widths: 32x33 signed product, rounding headroom, saturation input
  localparam int OPB_W  = 33;
  localparam int PROD_W = 65;
  localparam int RND_W  = 66;
  localparam int SAT_W  = 72;

  // divide-by-six unit: dividend width and bits retired per cycle
  localparam int DIV_W      = 48;
  localparam int DIV_DIGITS = 8;

  localparam logic [STEP_W-1:0]         STEP_SIZE_RST = 17'd3277;
  localparam logic signed [FORCE_W-1:0] FORCING_RST   = 25'sd524288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE = 1'b0,
    REG_FORCING   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] state_value;
    logic                    last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic                    last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DERIVE,
    S_ADVANCE,
    S_FINAL,
    S_DIV,
    S_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    RND_UNIT,
    RND_HALF,
    RND_SIXTH
  } rnd_mode_t;

  typedef struct packed {
    logic      mul_en;
    logic      rnd_en;
    rnd_mode_t rnd_mode;
  } arith_ctl_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-VAL_W:0] upper;
    logic signed [VAL_W-1:0] res;
    upper = v[SAT_W-1:VAL_W-1];
    if ((&upper) || !(|upper)) begin
      res = v[VAL_W-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/l96rk4_arith.sv -----
// ----------------------------------------------------------------------------
// l96rk4_arith: shared multiplier and rounding stage
// One registered 32x33 signed multiply, then a registered round-to-nearest
// (ties away from zero) rescale selected by the sequencer.
// ----------------------------------------------------------------------------
module l96rk4_arith #(
  parameter int FRACTION_BITS = l96rk4_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  l96rk4_pkg::arith_ctl_t                 ctl,
  input  logic signed [l96rk4_pkg::VAL_W-1:0]    op_a,
  input  logic signed [l96rk4_pkg::OPB_W-1:0]    op_b,
  output logic signed [l96rk4_pkg::RND_W-1:0]    rnd_o,
  output logic                                   neg_o
);

  localparam int RW = l96rk4_pkg::RND_W;

  logic signed [l96rk4_pkg::PROD_W-1:0] prod_r;
  logic signed [RW-1:0]                 rnd_r;
  logic                                 neg_r;

  logic [RW-1:0] pe;
  logic [RW-1:0] mag;
  logic [RW-1:0] bias;
  logic [RW-1:0] quo;
  logic          neg;
  logic [RW-1:0] rnd_nxt;

  // form magnitude, add half of the divisor, shift down, restore sign (the sixth mode keeps the magnitude)
  always_comb begin
    pe   = RW'(prod_r);
    neg  = prod_r[l96rk4_pkg::PROD_W-1];
    mag  = neg ? (~pe + RW'(1)) : pe;
    bias = RW'(1) << (FRACTION_BITS - 1);
    quo  = mag;
    rnd_nxt = mag;
    unique case (ctl.rnd_mode)
      l96rk4_pkg::RND_UNIT: begin
        bias = RW'(1) << (FRACTION_BITS - 1);
        quo  = (mag + bias) >> FRACTION_BITS;
        rnd_nxt = neg ? (~quo + RW'(1)) : quo;
      end
      l96rk4_pkg::RND_HALF: begin
        bias = RW'(1) << FRACTION_BITS;
        quo  = (mag + bias) >> (FRACTION_BITS + 1);
        rnd_nxt = neg ? (~quo + RW'(1)) : quo;
      end
      l96rk4_pkg::RND_SIXTH: begin
        // magnitude only; the divide by six finishes it
        bias = RW'(3) << FRACTION_BITS;
        quo  = (mag + bias) >> FRACTION_BITS;
        rnd_nxt = quo;
      end
      default: begin
        quo     = mag;
        rnd_nxt = mag;
      end
    endcase
  end

  // register product and rounded value
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= l96rk4_pkg::PROD_W'(op_a) * l96rk4_pkg::PROD_W'(op_b);
    end
    if (ctl.rnd_en) begin
      rnd_r <= $signed(rnd_nxt);
      neg_r <= neg;
    end
  end

  assign rnd_o = rnd_r;
  assign neg_o = neg_r;

endmodule

// ----- rtl/l96rk4_div6.sv -----
// ----------------------------------------------------------------------------
// l96rk4_div6: iterative unsigned divide by six
// Long division, MSB first, DIV_DIGITS quotient bits per cycle with a 3-bit
// remainder.
// ----------------------------------------------------------------------------
module l96rk4_div6 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [l96rk4_pkg::DIV_W-1:0]    dividend,
  output logic                            done,
  output logic [l96rk4_pkg::DIV_W-1:0]    quot
);

  localparam int DW    = l96rk4_pkg::DIV_W;
  localparam int DG    = l96rk4_pkg::DIV_DIGITS;
  localparam int STEPS = DW / DG;
  localparam int SCW   = $clog2(STEPS + 1);

  logic [DW-1:0]  work_r;
  logic [DW-1:0]  quot_r;
  logic [2:0]     rem_r;
  logic [SCW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;

  logic [DW-1:0] work_nxt;
  logic [DW-1:0] quot_nxt;
  logic [2:0]    rem_nxt;

  // retire DG dividend bits
  always_comb begin
    logic [3:0] t;
    work_nxt = work_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    for (int k = 0; k < DG; k++) begin
      t        = {rem_nxt, work_nxt[DW-1]};
      work_nxt = work_nxt << 1;
      if (t >= 4'd6) begin
        rem_nxt  = 3'(t - 4'd6);
        quot_nxt = {quot_nxt[DW-2:0], 1'b1};
      end else begin
        rem_nxt  = t[2:0];
        quot_nxt = {quot_nxt[DW-2:0], 1'b0};
      end
    end
  end

  // control: load on start, count down steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SCW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SCW'(1);
        if (cnt_r == SCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      quot_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      work_r <= work_nxt;
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- rtl/lorenz96_rk4_step.sv -----
// ----------------------------------------------------------------------------
// lorenz96_rk4_step: one RK4 step of a cyclic Lorenz-96 ring, Q16.16
// Loads the ring element by element, then runs four derivative/update
// passes and a final weighted update on one shared multiply-round unit.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall   | state_value, last_in
// out_    | output    | out_valid / out_stall | new_value, last_out
// cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// Loading accepts one element per cycle. After the last element the step runs
// 4 derivative passes (4 reads of the single stage-memory read port per element,
// then multiply and round), 4 update passes (multiply and round per element)
// and the final update per element (multiply, round, divide by six, output
// load). in_stall stays high from the last element until the final result is
// loaded into the output register. An output stall holds the sequencer in its
// emit state while the output register holds a result.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module lorenz96_rk4_step #(
  parameter int MAX_ELEMENTS  = l96rk4_pkg::MAX_ELEMENTS_DEF,
  parameter int FRACTION_BITS = l96rk4_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  l96rk4_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output l96rk4_pkg::out_item_t               out_data,
  input  logic                                cfg_we,
  input  logic [l96rk4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [l96rk4_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int AW  = $clog2(MAX_ELEMENTS);
  localparam int CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int TW  = CW + 2;
  localparam int VW  = l96rk4_pkg::VAL_W;
  localparam int SW  = l96rk4_pkg::SAT_W;
  localparam int DW  = l96rk4_pkg::DIV_W;

  // ring index wrap: bring t (< 3n) into 0..n-1
  function automatic logic [AW-1:0] ring_wrap(input logic [TW-1:0] t,
                                               input logic [CW-1:0] n);
    logic [TW-1:0] v;
    v = t;
    if (v >= TW'(n)) v = v - TW'(n);
    if (v >= TW'(n)) v = v - TW'(n);
    return v[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  l96rk4_pkg::seq_state_t state_r, state_nxt;
  logic [2:0]    sc_r, sc_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [1:0]    pass_r, pass_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;

  logic [l96rk4_pkg::STEP_W-1:0]         step_size_r;
  logic signed [l96rk4_pkg::FORCE_W-1:0] forcing_r;

  logic signed [VW-1:0] a_r;
  logic signed [VW-1:0] diff_r;
  logic signed [VW-1:0] xi_r;
  logic signed [VW-1:0] st_r;

  logic                  out_valid_r;
  l96rk4_pkg::out_item_t out_data_r;

  // memories
  logic signed [VW-1:0] start_mem [MAX_ELEMENTS];
  logic signed [VW-1:0] stage_mem [MAX_ELEMENTS];
  logic signed [VW-1:0] slope_mem [MAX_ELEMENTS];
  logic signed [VW-1:0] wsum_mem  [MAX_ELEMENTS];
  logic signed [VW-1:0] start_q, stage_q, slope_q, wsum_q;

  logic [AW-1:0]        stage_ra, wr_a;
  logic                 start_we, stage_we, slope_we, wsum_we;
  logic signed [VW-1:0] stage_wd, slope_wd, wsum_wd;

  // shared unit
  l96rk4_pkg::arith_ctl_t                   actl;
  logic signed [VW-1:0]                     op_a;
  logic signed [l96rk4_pkg::OPB_W-1:0]      op_b;
  logic signed [l96rk4_pkg::RND_W-1:0]      rnd;
  logic                                     rnd_neg;
  logic                                     div_start;
  logic                                     div_done;
  logic [DW-1:0]                            div_q;

  // derived values
  logic          in_acc;
  logic          last_elem;
  logic          out_free;
  logic          out_load;
  logic [AW-1:0] ip1, im1, im2;
  logic signed [VW-1:0] slope_val, wsum_val, stage_val, diff_val, final_val;
  logic signed [SW-1:0] acc_w, k_w, qs_w;
  logic signed [DW:0]   qs;

  assign in_acc    = in_valid && !in_stall;
  assign last_elem = (CW'(idx_r) == n_r - CW'(1));
  assign out_free  = !out_valid_r || !out_stall;

  assign ip1 = ring_wrap(TW'(idx_r) + TW'(1), n_r);
  assign im1 = ring_wrap(TW'(idx_r) + TW'(n_r) - TW'(1), n_r);
  assign im2 = ring_wrap(TW'(idx_r) + (TW'(n_r) << 1) - TW'(2), n_r);

  // arithmetic around the shared unit
  assign diff_val  = l96rk4_pkg::sat32(SW'(a_r) - SW'(stage_q));
  assign slope_val = l96rk4_pkg::sat32(SW'(rnd) - SW'(xi_r) + SW'(forcing_r));
  assign acc_w     = (pass_r == 2'd0) ? '0 : SW'(wsum_q);
  assign k_w       = ((pass_r == 2'd1) || (pass_r == 2'd2)) ? (SW'(slope_q) <<< 1)
                                                            : SW'(slope_q);
  assign wsum_val  = l96rk4_pkg::sat32(acc_w + k_w);
  assign stage_val = l96rk4_pkg::sat32(SW'(st_r) + SW'(rnd));
  assign qs        = rnd_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign qs_w      = SW'(qs);
  assign final_val = l96rk4_pkg::sat32(SW'(st_r) + qs_w);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      l96rk4_pkg::S_LOAD: begin
        if (in_acc && in_data.last_in) state_nxt = l96rk4_pkg::S_DERIVE;
      end
      l96rk4_pkg::S_DERIVE: begin
        if (sc_r == 3'd5 && last_elem) state_nxt = l96rk4_pkg::S_ADVANCE;
      end
      l96rk4_pkg::S_ADVANCE: begin
        if (sc_r == 3'd3 && last_elem) begin
          state_nxt = (pass_r == 2'd3) ? l96rk4_pkg::S_FINAL : l96rk4_pkg::S_DERIVE;
        end
      end
      l96rk4_pkg::S_FINAL: begin
        if (sc_r == 3'd3) state_nxt = l96rk4_pkg::S_DIV;
      end
      l96rk4_pkg::S_DIV: begin
        if (div_done) state_nxt = l96rk4_pkg::S_EMIT;
      end
      l96rk4_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = last_elem ? l96rk4_pkg::S_LOAD : l96rk4_pkg::S_FINAL;
        end
      end
      default: state_nxt = l96rk4_pkg::S_LOAD;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer outputs: memory ports, shared unit control, counters
  // --------------------------------------------------------------------------
  always_comb begin
    stage_ra  = idx_r;
    wr_a      = idx_r;
    start_we  = 1'b0;
    stage_we  = 1'b0;
    slope_we  = 1'b0;
    wsum_we   = 1'b0;
    stage_wd  = stage_val;
    slope_wd  = slope_val;
    wsum_wd   = wsum_val;
    actl      = '{mul_en: 1'b0, rnd_en: 1'b0, rnd_mode: l96rk4_pkg::RND_UNIT};
    op_a      = slope_q;
    op_b      = $signed({{(l96rk4_pkg::OPB_W - l96rk4_pkg::STEP_W){1'b0}}, step_size_r});
    div_start = 1'b0;
    out_load  = 1'b0;
    sc_nxt    = sc_r + 3'd1;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    unique case (state_r)
      l96rk4_pkg::S_LOAD: begin
        sc_nxt = '0;
        wr_a   = cnt_r[AW-1:0];
        stage_wd = in_data.state_value;
        if (in_acc) begin
          if (cnt_r < CW'(MAX_ELEMENTS)) begin
            start_we = 1'b1;
            stage_we = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end
          if (in_data.last_in) begin
            n_nxt    = (cnt_r < CW'(MAX_ELEMENTS)) ? cnt_r + CW'(1) : cnt_r;
            cnt_nxt  = '0;
            idx_nxt  = '0;
            pass_nxt = '0;
          end
        end
      end
      l96rk4_pkg::S_DERIVE: begin
        unique case (sc_r)
          3'd0: stage_ra = ip1;
          3'd1: stage_ra = im2;
          3'd2: stage_ra = im1;
          3'd3: begin
            actl.mul_en = 1'b1;
            op_a = diff_r;
            op_b = l96rk4_pkg::OPB_W'(stage_q);
          end
          3'd4: begin
            actl.rnd_en   = 1'b1;
            actl.rnd_mode = l96rk4_pkg::RND_UNIT;
          end
          3'd5: begin
            slope_we = 1'b1;
            sc_nxt   = '0;
            idx_nxt  = last_elem ? '0 : idx_r + AW'(1);
          end
          default: sc_nxt = '0;
        endcase
      end
      l96rk4_pkg::S_ADVANCE: begin
        unique case (sc_r)
          3'd0: ;
          3'd1: begin
            wsum_we     = 1'b1;
            actl.mul_en = 1'b1;
          end
          3'd2: begin
            actl.rnd_en   = 1'b1;
            actl.rnd_mode = (pass_r == 2'd2) ? l96rk4_pkg::RND_UNIT : l96rk4_pkg::RND_HALF;
          end
          3'd3: begin
            stage_we = (pass_r != 2'd3);
            sc_nxt   = '0;
            idx_nxt  = last_elem ? '0 : idx_r + AW'(1);
            if (last_elem) pass_nxt = pass_r + 2'd1;
          end
          default: sc_nxt = '0;
        endcase
      end
      l96rk4_pkg::S_FINAL: begin
        unique case (sc_r)
          3'd0: ;
          3'd1: begin
            actl.mul_en = 1'b1;
            op_a = wsum_q;
          end
          3'd2: begin
            actl.rnd_en   = 1'b1;
            actl.rnd_mode = l96rk4_pkg::RND_SIXTH;
          end
          3'd3: begin
            div_start = 1'b1;
            sc_nxt    = '0;
          end
          default: sc_nxt = '0;
        endcase
      end
      l96rk4_pkg::S_DIV: begin
        sc_nxt = '0;
      end
      l96rk4_pkg::S_EMIT: begin
        sc_nxt = '0;
        if (out_free) begin
          out_load = 1'b1;
          idx_nxt  = last_elem ? '0 : idx_r + AW'(1);
        end
      end
      default: sc_nxt = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= l96rk4_pkg::S_LOAD;
      sc_r        <= '0;
      idx_r       <= '0;
      pass_r      <= '0;
      cnt_r       <= '0;
      n_r         <= CW'(1);
      step_size_r <= l96rk4_pkg::STEP_SIZE_RST;
      forcing_r   <= l96rk4_pkg::FORCING_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      // configuration writes
      if (cfg_we) begin
        unique case (l96rk4_pkg::cfg_reg_t'(cfg_index))
          l96rk4_pkg::REG_STEP_SIZE: step_size_r <= cfg_wdata[l96rk4_pkg::STEP_W-1:0];
          l96rk4_pkg::REG_FORCING:   forcing_r   <= $signed(cfg_wdata[l96rk4_pkg::FORCE_W-1:0]);
          default: ;
        endcase
      end
      // output register: load or drain
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == l96rk4_pkg::S_DERIVE && sc_r == 3'd1) a_r    <= stage_q;
    if (state_r == l96rk4_pkg::S_DERIVE && sc_r == 3'd2) diff_r <= diff_val;
    if (state_r == l96rk4_pkg::S_DERIVE && sc_r == 3'd4) xi_r   <= stage_q;
    if ((state_r == l96rk4_pkg::S_ADVANCE || state_r == l96rk4_pkg::S_FINAL) &&
        sc_r == 3'd1) begin
      st_r <= start_q;
    end
    if (out_load) begin
      out_data_r.new_value <= final_val;
      out_data_r.last_out  <= last_elem;
    end
  end

  // --------------------------------------------------------------------------
  // vector memories: one write and one registered read port each
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (start_we) start_mem[wr_a] <= in_data.state_value;
    start_q <= start_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[wr_a] <= stage_wd;
    stage_q <= stage_mem[stage_ra];
  end

  always_ff @(posedge clk) begin
    if (slope_we) slope_mem[wr_a] <= slope_wd;
    slope_q <= slope_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (wsum_we) wsum_mem[wr_a] <= wsum_wd;
    wsum_q <= wsum_mem[idx_r];
  end

  // --------------------------------------------------------------------------
  // shared multiply/round unit and divide-by-six unit
  // --------------------------------------------------------------------------
  l96rk4_arith #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_arith (
    .clk   (clk),
    .ctl   (actl),
    .op_a  (op_a),
    .op_b  (op_b),
    .rnd_o (rnd),
    .neg_o (rnd_neg)
  );

  l96rk4_div6 u_div6 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd[DW-1:0]),
    .done     (div_done),
    .quot     (div_q)
  );

  assign in_stall  = (state_r != l96rk4_pkg::S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/l96rk4_checker.sv -----
// ----------------------------------------------------------------------------
// l96rk4_checker: port-level checks for lorenz96_rk4_step
// Watches the input and output channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module l96rk4_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input l96rk4_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input l96rk4_pkg::out_item_t out_data
);

  // block is ready to load right after reset
  ast_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("in_stall high after reset");

  // a marked last element starts the step and closes the input
  ast_last_starts_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_in) |=> in_stall)
    else $error("input not closed after last element");

  // a plain element keeps the input open
  ast_load_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.last_in) |=> !in_stall)
    else $error("input closed after non-last element");

  // new results appear only while a step is in progress
  ast_result_during_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a step");

  // a stalled result holds
  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output transaction changed");

endmodule

bind lorenz96_rk4_step l96rk4_checker u_l96rk4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_lorenz96_rk4_step.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lorenz96_rk4_step: self-checking bench for the Lorenz-96 RK4 stepper
// Loads rings of random length and content, predicts every advanced element
// with a fixed-point RK4 model kept in the bench, and checks each result in
// order under random input gaps, output stalls and several register settings.
// ----------------------------------------------------------------------------
module tb_lorenz96_rk4_step;

  localparam int RING_MAX   = 64;
  localparam int FRAC       = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  l96rk4_pkg::in_item_t             in_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  l96rk4_pkg::out_item_t            out_data;
  logic                             cfg_we = 1'b0;
  logic [l96rk4_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [l96rk4_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // predictor state: loaded ring and register copies
  int                                      ring_buf [RING_MAX];
  int                                      ring_cnt;
  int                                      h_val;
  logic signed [l96rk4_pkg::FORCE_W-1:0]   f_val;
  l96rk4_pkg::out_item_t                   exp_ring_q [$];

  int  fail_cnt = 0;
  int  ring_cnt_total;
  int  result_cnt = 0;
  int  item_cnt;
  bit  gaps_on;
  bit  hold_req = 1'b0;
  bit  hold_on = 1'b0;
  int  idle_cycles = 0;

  lorenz96_rk4_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint div_near(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  task automatic ring_slopes(input int n, input int stg [RING_MAX], output int slp [RING_MAX]);
    longint diff;
    longint prod;
    for (int i = 0; i < n; i++) begin
      diff = clamp32(longint'(stg[(i + 1) % n]) - longint'(stg[(i + 2 * n - 2) % n]));
      prod = div_near(diff * longint'(stg[(i + n - 1) % n]), 64'd1 << FRAC);
      slp[i] = clamp32(prod - longint'(stg[i]) + longint'(f_val));
    end
  endtask

  // advance the loaded ring by one RK4 step and queue the expected elements
  task automatic ring_predict();
    int                    n;
    int                    stg [RING_MAX];
    int                    slp [RING_MAX];
    int                    wsum [RING_MAX];
    int                    shift;
    longint                weight;
    longint                acc;
    longint                inc;
    l96rk4_pkg::out_item_t res;
    n = ring_cnt;
    ring_cnt = 0;
    stg = ring_buf;
    for (int pass = 0; pass < 4; pass++) begin
      ring_slopes(n, stg, slp);
      shift  = (pass < 2) ? FRAC + 1 : FRAC;
      weight = (pass == 0 || pass == 3) ? 1 : 2;
      for (int i = 0; i < n; i++) begin
        acc = (pass == 0) ? 0 : longint'(wsum[i]);
        wsum[i] = clamp32(acc + weight * longint'(slp[i]));
        if (pass < 3) begin
          inc = div_near(longint'(slp[i]) * longint'(h_val), 64'd1 << shift);
          stg[i] = clamp32(longint'(ring_buf[i]) + inc);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      inc = div_near(longint'(wsum[i]) * longint'(h_val), 64'd6 << FRAC);
      res.new_value = clamp32(longint'(ring_buf[i]) + inc);
      res.last_out  = (i == n - 1);
      exp_ring_q.push_back(res);
    end
    ring_cnt_total++;
  endtask

  // ------------------------------------------------------------------ drivers
  // offer one element, hold it until accepted, then update the prediction
  task automatic send_element(input int value, input bit last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.state_value <= value;
    in_data.last_in <= last;
    do @(posedge clk); while (in_stall);
    item_cnt++;
    if (ring_cnt < RING_MAX) begin
      ring_buf[ring_cnt] = value;
      ring_cnt++;
    end
    if (last) ring_predict();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_ring_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // write one register while the block is idle
  task automatic write_reg(input l96rk4_pkg::cfg_reg_t idx, input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= l96rk4_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == l96rk4_pkg::REG_STEP_SIZE) h_val = value & 32'h1ffff;
    else f_val = l96rk4_pkg::FORCE_W'(value);
  endtask

  function automatic int pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $signed($urandom_range(0, 2621440)) - 1310720;
    if (sel < 9) return $urandom();
    return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
  endfunction

  task automatic send_ring(input int n);
    for (int i = 0; i < n; i++) send_element(pick_value(), i == n - 1);
  endtask

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return $urandom_range(1, 8);
    if (sel < 19) return $urandom_range(9, 24);
    return $urandom_range(60, 68);
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    l96rk4_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_cnt++;
      if (exp_ring_q.size() == 0) begin
        $error("result with no expectation: new_value %0d", $signed(out_data.new_value));
        fail_cnt++;
      end else begin
        want = exp_ring_q.pop_front();
        if (out_data.new_value !== want.new_value) begin
          $error("new_value expected %0d actual %0d", $signed(want.new_value),
                 $signed(out_data.new_value));
          fail_cnt++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out expected %0b actual %0b", want.last_out, out_data.last_out);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: draw a pause after each result, merge in the long hold
  always @(posedge clk) begin
    static int pause = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) pause = gaps_on ? $urandom_range(0, 4) : 0;
      if (hold_on) begin
        out_stall <= 1'b1;
      end else if (pause > 0) begin
        pause--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long output hold, counted here once requested
  initial begin
    wait (hold_req);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_on <= 1'b0;
  end

  // watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lorenz96_rk4_step failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_directed();
    gaps_on = 1'b0;
    send_element(0, 1'b1);
    send_element(32'h7fffffff, 1'b0);
    send_element(32'h80000000, 1'b1);
    send_element(32'h7fffffff, 1'b0);
    send_element(32'h80000000, 1'b0);
    send_element(32'hffffffff, 1'b1);
    send_element(8 << FRAC, 1'b0);
    send_element(1 << FRAC, 1'b0);
    send_element(-(3 << FRAC), 1'b0);
    send_element(32'h00018000, 1'b1);
    write_reg(l96rk4_pkg::REG_STEP_SIZE, 65536);
    write_reg(l96rk4_pkg::REG_FORCING, 8388608);
    send_element(32'h55555555, 1'b0);
    send_element(32'haaaaaaaa, 1'b0);
    send_element(12 << FRAC, 1'b1);
    write_reg(l96rk4_pkg::REG_STEP_SIZE, 0);
    write_reg(l96rk4_pkg::REG_FORCING, -8388608);
    send_element(5 << FRAC, 1'b0);
    send_element(-(5 << FRAC), 1'b0);
    send_element(7, 1'b1);
    write_reg(l96rk4_pkg::REG_STEP_SIZE, 3277);
    write_reg(l96rk4_pkg::REG_FORCING, 524288);
  endtask

  // overfill the ring so that the extra elements are dropped
  task automatic test_full_ring();
    gaps_on = 1'b1;
    send_ring(70);
    send_ring(RING_MAX);
  endtask

  task automatic test_settings();
    int steps [4] = '{1, 65536, 131071, 6554};
    int forces [4] = '{0, 8388608, -8388608, 33554431};
    gaps_on = 1'b1;
    for (int s = 0; s < 4; s++) begin
      write_reg(l96rk4_pkg::REG_STEP_SIZE, steps[s]);
      write_reg(l96rk4_pkg::REG_FORCING, forces[s]);
      repeat (3) send_ring($urandom_range(1, 6));
    end
    write_reg(l96rk4_pkg::REG_STEP_SIZE, 3277);
    write_reg(l96rk4_pkg::REG_FORCING, 524288);
  endtask

  task automatic test_random();
    int target;
    target = item_cnt + 300;
    while (item_cnt < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 15) == 0) begin
        write_reg(l96rk4_pkg::REG_STEP_SIZE, $urandom_range(0, 65536));
        write_reg(l96rk4_pkg::REG_FORCING, $signed($urandom_range(0, 16777216)) - 8388608);
      end
      send_ring(pick_len());
    end
  endtask

  // hold off the output while more rings are offered
  task automatic test_backpressure();
    gaps_on = 1'b0;
    drain();
    hold_req = 1'b1;
    send_ring(8);
    send_ring(5);
    send_ring(3);
  endtask

  initial begin
    bit lost;
    lost = 1'b0;
    ring_cnt = 0;
    ring_cnt_total = 0;
    item_cnt = 0;
    gaps_on = 1'b0;
    h_val = 3277;
    f_val = l96rk4_pkg::FORCING_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_ring();
    test_settings();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (exp_ring_q.size() != 0) begin
      $error("%0d expected results never arrived", exp_ring_q.size());
      lost = 1'b1;
    end
    $display("Covered %0d elements in %0d rings, %0d results checked,", item_cnt,
             ring_cnt_total, result_cnt);
    $display("with register extremes, overfilled rings and a long output hold.");
    if (fail_cnt == 0 && !lost) begin
      $display("tb_lorenz96_rk4_step passed");
    end else begin
      $display("tb_lorenz96_rk4_step failed");
    end
    $finish;
  end

endmodule
